>>> rtl/plci_pkg.sv
// plci_pkg: shared types, codes and helpers for the packet loss and corrupt
// impairment unit. No dependencies.

package plci_pkg;

  localparam int unsigned LEN_W  = 13;
  localparam int unsigned WORD_W = 32;
  localparam int unsigned IDX_W  = 3;

  // register indexes on the configuration channel
  localparam logic [IDX_W-1:0] REG_MODEL_SEL    = 3'd0;
  localparam logic [IDX_W-1:0] REG_LOSS_PROB    = 3'd1;
  localparam logic [IDX_W-1:0] REG_THRESH_A1    = 3'd2;
  localparam logic [IDX_W-1:0] REG_THRESH_A2    = 3'd3;
  localparam logic [IDX_W-1:0] REG_THRESH_A3    = 3'd4;
  localparam logic [IDX_W-1:0] REG_THRESH_A4    = 3'd5;
  localparam logic [IDX_W-1:0] REG_THRESH_A5    = 3'd6;
  localparam logic [IDX_W-1:0] REG_CORRUPT_PROB = 3'd7;

  // loss model selector codes
  localparam logic [1:0] LM_RANDOM     = 2'd0;
  localparam logic [1:0] LM_GILBERT    = 2'd1;
  localparam logic [1:0] LM_FOUR_STATE = 2'd2;

  // verdict codes
  localparam logic [1:0] VERDICT_PASS  = 2'd0;
  localparam logic [1:0] VERDICT_DROP  = 2'd1;
  localparam logic [1:0] VERDICT_ABORT = 2'd2;

  // decision queue between front and back
  localparam int unsigned QUEUE_AW    = 1;
  localparam int unsigned QUEUE_DEPTH = 1 << QUEUE_AW;

  // remainder unit: four quotient bits per cycle over a 32-bit padded dividend
  localparam int unsigned DIGIT_W   = 4;
  localparam int unsigned DIV_STEPS = WORD_W / DIGIT_W;
  localparam int unsigned CNT_W     = $clog2(DIV_STEPS);

  typedef struct packed {
    logic              lost;
    logic              corrupt;
    logic [LEN_W-1:0]  len;
    logic [WORD_W-1:0] position;
  } job_t;

  // four restoring steps of the remainder; rem stays below div
  function automatic logic [LEN_W-1:0] mod_step(input logic [LEN_W-1:0]   rem,
                                                input logic [DIGIT_W-1:0] digit,
                                                input logic [LEN_W-1:0]   div);
    logic [LEN_W-1:0] r;
    logic [LEN_W:0]   t;
    r = rem;
    for (int i = DIGIT_W - 1; i >= 0; i--) begin
      t = {r, digit[i]};
      if (t >= {1'b0, div}) begin
        t = t - {1'b0, div};
      end
      r = t[LEN_W-1:0];
    end
    return r;
  endfunction

endpackage

>>> rtl/plci_front.sv
// plci_front: configuration registers, loss model and corruption draw.
// Uses plci_pkg; pushes one job per accepted descriptor into plci_queue.

module plci_front #(
  parameter int unsigned MAX_PACKET_BYTES = 8191
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_valid,
  input  logic [plci_pkg::IDX_W-1:0]  cfg_index,
  input  logic [plci_pkg::WORD_W-1:0] cfg_data,
  input  logic                        in_valid,
  input  logic                        q_full,
  input  logic [plci_pkg::LEN_W-1:0]  packet_len,
  input  logic [plci_pkg::WORD_W-1:0] rand_loss_a,
  input  logic [plci_pkg::WORD_W-1:0] rand_loss_b,
  input  logic [plci_pkg::WORD_W-1:0] rand_corrupt,
  input  logic [plci_pkg::WORD_W-1:0] rand_position,
  output logic                        push,
  output plci_pkg::job_t              job
);

  typedef enum logic [1:0] {
    LS_GOOD,
    LS_BAD,
    LS_LOST_GAP,
    LS_LOST_BURST
  } loss_state_t;

  localparam logic [plci_pkg::LEN_W-1:0] MAX_LEN = plci_pkg::LEN_W'(MAX_PACKET_BYTES);

  logic [1:0]                  model_sel;
  logic [plci_pkg::WORD_W-1:0] loss_prob;
  logic [plci_pkg::WORD_W-1:0] thresh_a1;
  logic [plci_pkg::WORD_W-1:0] thresh_a2;
  logic [plci_pkg::WORD_W-1:0] thresh_a3;
  logic [plci_pkg::WORD_W-1:0] thresh_a4;
  logic [plci_pkg::WORD_W-1:0] thresh_a5;
  logic [plci_pkg::WORD_W-1:0] corrupt_prob;
  loss_state_t                 loss_state;
  loss_state_t                 loss_state_next;
  logic                        lost;
  logic [plci_pkg::WORD_W-1:0] s14;
  logic [plci_pkg::WORD_W-1:0] s23;

  assign push = in_valid && !q_full;

  assign s14 = thresh_a1 + thresh_a4;
  assign s23 = thresh_a2 + thresh_a3;

  always_comb begin
    lost            = 1'b0;
    loss_state_next = loss_state;
    case (model_sel)
      plci_pkg::LM_RANDOM: begin
        lost = (loss_prob != '0) && (loss_prob >= rand_loss_a);
      end
      plci_pkg::LM_GILBERT: begin
        case (loss_state)
          LS_GOOD: begin
            if (rand_loss_a < thresh_a1) begin
              loss_state_next = LS_BAD;
            end
            lost = rand_loss_b < thresh_a4;
          end
          LS_BAD: begin
            if (rand_loss_a < thresh_a2) begin
              loss_state_next = LS_GOOD;
            end
            lost = rand_loss_b > thresh_a3;
          end
          default: ;
        endcase
      end
      plci_pkg::LM_FOUR_STATE: begin
        case (loss_state)
          LS_GOOD: begin
            if (rand_loss_a < thresh_a4) begin
              loss_state_next = LS_LOST_GAP;
              lost            = 1'b1;
            end else if (thresh_a4 < rand_loss_a && rand_loss_a < s14) begin
              loss_state_next = LS_LOST_BURST;
              lost            = 1'b1;
            end
          end
          LS_BAD: begin
            if (rand_loss_a < thresh_a5) begin
              loss_state_next = LS_LOST_BURST;
              lost            = 1'b1;
            end
          end
          LS_LOST_BURST: begin
            if (rand_loss_a < thresh_a3) begin
              loss_state_next = LS_BAD;
            end else if (thresh_a3 < rand_loss_a && rand_loss_a < s23) begin
              loss_state_next = LS_GOOD;
            end else if (s23 < rand_loss_a) begin
              lost = 1'b1;
            end
          end
          default: begin
            loss_state_next = LS_GOOD;
          end
        endcase
      end
      default: ;
    endcase
  end

  always_comb begin
    job.lost     = lost;
    job.corrupt  = (corrupt_prob != '0) && (corrupt_prob >= rand_corrupt);
    job.len      = (packet_len > MAX_LEN) ? MAX_LEN : packet_len;
    job.position = rand_position;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      model_sel    <= plci_pkg::LM_RANDOM;
      loss_prob    <= '0;
      thresh_a1    <= '0;
      thresh_a2    <= '0;
      thresh_a3    <= '0;
      thresh_a4    <= '0;
      thresh_a5    <= '0;
      corrupt_prob <= '0;
      loss_state   <= LS_GOOD;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          plci_pkg::REG_MODEL_SEL:    model_sel    <= cfg_data[1:0];
          plci_pkg::REG_LOSS_PROB:    loss_prob    <= cfg_data;
          plci_pkg::REG_THRESH_A1:    thresh_a1    <= cfg_data;
          plci_pkg::REG_THRESH_A2:    thresh_a2    <= cfg_data;
          plci_pkg::REG_THRESH_A3:    thresh_a3    <= cfg_data;
          plci_pkg::REG_THRESH_A4:    thresh_a4    <= cfg_data;
          plci_pkg::REG_THRESH_A5:    thresh_a5    <= cfg_data;
          plci_pkg::REG_CORRUPT_PROB: corrupt_prob <= cfg_data;
          default: ;
        endcase
      end
      if (push) begin
        loss_state <= loss_state_next;
      end
    end
  end

endmodule

>>> rtl/plci_queue.sv
// plci_queue: short job queue that decouples the loss front from the
// corruption back. Uses plci_pkg::job_t.

module plci_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  plci_pkg::job_t push_job,
  output logic           full,
  input  logic           pop,
  output plci_pkg::job_t head,
  output logic           empty
);

  plci_pkg::job_t                entries [plci_pkg::QUEUE_DEPTH];
  logic [plci_pkg::QUEUE_AW-1:0] wr_ptr;
  logic [plci_pkg::QUEUE_AW-1:0] rd_ptr;
  logic [plci_pkg::QUEUE_AW:0]   count;
  logic [plci_pkg::QUEUE_AW:0]   count_next;

  assign full  = (count == (plci_pkg::QUEUE_AW+1)'(plci_pkg::QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head  = entries[rd_ptr];

  always_comb begin
    count_next = count;
    if (push && !pop) begin
      count_next = count + 1'b1;
    end else if (pop && !push) begin
      count_next = count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

endmodule

>>> rtl/plci_back.sv
// plci_back: pops jobs, reduces the flip position with a 4-bit-per-cycle
// remainder unit and holds the result register. Uses plci_pkg.

module plci_back (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       q_empty,
  input  plci_pkg::job_t             q_head,
  output logic                       pop,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [1:0]                 verdict,
  output logic                       flip_valid,
  output logic [plci_pkg::LEN_W-1:0] flip_offset,
  output logic [7:0]                 flip_mask
);

  typedef enum logic [1:0] {
    B_IDLE,
    B_DIV,
    B_FINISH
  } back_state_t;

  back_state_t                 state;
  logic [plci_pkg::CNT_W-1:0]  cnt;
  logic [plci_pkg::WORD_W-1:0] dvd;
  logic [plci_pkg::LEN_W-1:0]  rem;
  logic [plci_pkg::LEN_W-1:0]  divisor;
  logic [2:0]                  bit_sel;
  logic                        can_load;
  logic                        needs_div;
  logic                        at_end;
  logic                        load_out;

  assign can_load  = !out_valid || !out_stall;
  assign needs_div = !q_head.lost && q_head.corrupt && (q_head.len != '0);
  // offset + 1 >= len means the flip would land on or past the last byte
  assign at_end    = ({1'b0, rem} + 1'b1) >= {1'b0, divisor};
  // a new result goes into the output register this cycle
  assign load_out  = (state == B_IDLE && pop && !needs_div) ||
                     (state == B_FINISH && can_load);

  always_comb begin
    pop = 1'b0;
    if (state == B_IDLE && !q_empty) begin
      pop = needs_div || can_load;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        B_IDLE: begin
          if (pop) begin
            if (needs_div) begin
              // offset = (position / 8) mod len, bit = position mod 8
              dvd     <= {3'b000, q_head.position[plci_pkg::WORD_W-1:3]};
              rem     <= '0;
              divisor <= q_head.len;
              bit_sel <= q_head.position[2:0];
              cnt     <= '0;
              state   <= B_DIV;
            end else begin
              flip_valid  <= 1'b0;
              flip_offset <= '0;
              flip_mask   <= '0;
              if (q_head.lost) begin
                verdict <= plci_pkg::VERDICT_DROP;
              end else if (q_head.corrupt) begin
                verdict <= plci_pkg::VERDICT_ABORT;
              end else begin
                verdict <= plci_pkg::VERDICT_PASS;
              end
            end
          end
        end
        B_DIV: begin
          rem <= plci_pkg::mod_step(rem,
                                    dvd[plci_pkg::WORD_W-1 -: plci_pkg::DIGIT_W],
                                    divisor);
          dvd <= dvd << plci_pkg::DIGIT_W;
          cnt <= cnt + 1'b1;
          if (cnt == plci_pkg::CNT_W'(plci_pkg::DIV_STEPS - 1)) begin
            state <= B_FINISH;
          end
        end
        B_FINISH: begin
          if (can_load) begin
            state <= B_IDLE;
            if (at_end) begin
              verdict     <= plci_pkg::VERDICT_ABORT;
              flip_valid  <= 1'b0;
              flip_offset <= '0;
              flip_mask   <= '0;
            end else begin
              verdict     <= plci_pkg::VERDICT_PASS;
              flip_valid  <= 1'b1;
              flip_offset <= rem;
              flip_mask   <= 8'(1) << bit_sel;
            end
          end
        end
        default: begin
          state <= B_IDLE;
        end
      endcase
    end
  end

  a_flip_mask_onehot: assert property (@(posedge clk) disable iff (rst)
    out_valid && flip_valid |-> $onehot(flip_mask) && verdict == plci_pkg::VERDICT_PASS)
    else $error("flip result without a one-hot mask or with a non-pass verdict");

  a_no_flip_on_reject: assert property (@(posedge clk) disable iff (rst)
    out_valid && verdict != plci_pkg::VERDICT_PASS |-> !flip_valid && flip_offset == '0)
    else $error("drop or abort carries flip data");

  a_div_length: assert property (@(posedge clk) disable iff (rst)
    state == B_DIV && cnt == plci_pkg::CNT_W'(plci_pkg::DIV_STEPS - 1) |=> state == B_FINISH)
    else $error("remainder unit did not finish after its last step");

  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    state == B_FINISH |-> rem < divisor)
    else $error("remainder not below packet length");

  a_no_pop_while_busy: assert property (@(posedge clk) disable iff (rst)
    state != B_IDLE |-> !pop)
    else $error("job taken while the remainder unit is busy");

endmodule

>>> rtl/packet_loss_and_corrupt_impairment_unit.sv
// Packet loss and bit-corruption decision unit for link impairment.
// Instantiates plci_front, plci_queue and plci_back; uses plci_pkg.
//
// Usage:
//   Input channel (in_valid / in_stall) takes one packet descriptor per
//   transfer: length and four random words. Output channel (out_valid /
//   out_stall) gives exactly one result per descriptor, in order: verdict
//   (pass, drop, abort) and the byte offset and XOR mask of a bit flip.
//   The configuration channel (cfg_valid / cfg_ready, always ready) writes
//   the eight registers by index; write only while the unit is idle.
//   A dropped, clean or zero-length packet passes the queue entry and the
//   result register; one with a flip position also passes the back-end
//   remainder unit, four quotient bits a cycle. The unit takes one packet
//   per cycle without a flip position while the receiver does not stall;
//   with one, the back end takes no new job until its result is loaded. A
//   two-entry queue lets the loss front keep taking descriptors while the
//   back end works or the receiver stalls; when the queue is full in_stall
//   rises. A stalled result stays on the outputs. Reset (rst, synchronous)
//   clears the configuration registers to zero, the loss state to good /
//   transmit-in-gap, and empties the queue and result register.

module packet_loss_and_corrupt_impairment_unit #(
  parameter int unsigned MAX_PACKET_BYTES = 8191
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [plci_pkg::IDX_W-1:0]  cfg_index,
  input  logic [plci_pkg::WORD_W-1:0] cfg_data,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [plci_pkg::LEN_W-1:0]  packet_len,
  input  logic [plci_pkg::WORD_W-1:0] rand_loss_a,
  input  logic [plci_pkg::WORD_W-1:0] rand_loss_b,
  input  logic [plci_pkg::WORD_W-1:0] rand_corrupt,
  input  logic [plci_pkg::WORD_W-1:0] rand_position,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [1:0]                  verdict,
  output logic                        flip_valid,
  output logic [plci_pkg::LEN_W-1:0]  flip_offset,
  output logic [7:0]                  flip_mask
);

  logic           q_full;
  logic           q_empty;
  logic           push;
  logic           pop;
  plci_pkg::job_t push_job;
  plci_pkg::job_t q_head;

  assign cfg_ready = 1'b1;
  assign in_stall  = q_full;

  plci_front #(
    .MAX_PACKET_BYTES(MAX_PACKET_BYTES)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid && cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .q_full       (q_full),
    .packet_len   (packet_len),
    .rand_loss_a  (rand_loss_a),
    .rand_loss_b  (rand_loss_b),
    .rand_corrupt (rand_corrupt),
    .rand_position(rand_position),
    .push         (push),
    .job          (push_job)
  );

  plci_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_job(push_job),
    .full    (q_full),
    .pop     (pop),
    .head    (q_head),
    .empty   (q_empty)
  );

  plci_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_empty    (q_empty),
    .q_head     (q_head),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .verdict    (verdict),
    .flip_valid (flip_valid),
    .flip_offset(flip_offset),
    .flip_mask  (flip_mask)
  );

endmodule
